FILE: hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared widths, operation and status codes, and the result metadata type
// for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DATA_W       = 32;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int OCC_W        = 4;
  localparam int CAPACITY_DEF = 8;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // result fields that come from the control side
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
    logic                is_empty;
    logic                is_full;
    logic                take_data;
  } res_meta_t;

endpackage

FILE: hdl/dq_if.sv
// ----------------------------------------------------------------------------
// dq_in_if / dq_out_if
// Valid/ready channels that carry one operation word in and one result
// word out.
// ----------------------------------------------------------------------------
interface dq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [dq_pkg::KIND_W-1:0]            kind;
  logic signed [dq_pkg::DATA_W-1:0]     push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface dq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dq_pkg::DATA_W-1:0]     pop_value;
  logic [dq_pkg::STATUS_W-1:0]          status;
  logic [dq_pkg::OCC_W-1:0]             occupancy;
  logic                                 is_empty;
  logic                                 is_full;

  modport source (output valid, output pop_value, output status, output occupancy,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  input is_empty, input is_full, output ready);
endinterface

FILE: hdl/double_ended_queue.sv
// A result word is valid in the cycle after its operation word is accepted;
// the registered read of the slot memory is the register in between.
// Throughput: one operation per cycle while the result side keeps ready high;
// a single result register holds each word, so a stalled result blocks new words.
// Reset (rst, synchronous) clears head, tail, count and the pending result;
// slot contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words in a circular slot memory with push
// and pop at either end, overflow and underflow status and occupancy flags.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dq_in_if.sink      in_ch,
  dq_out_if.source   out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic                        accept, out_take;
  logic                        we, re, pend;
  logic [IDX_W-1:0]            waddr, raddr;
  logic [dq_pkg::DATA_W-1:0]   wdata, rd_data;
  dq_pkg::res_meta_t           meta;

  // take a new word when no result is waiting or it leaves this cycle
  assign in_ch.ready = !pend || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_take    = out_ch.valid && out_ch.ready;

  dq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (in_ch.kind),
    .push_value (in_ch.push_value),
    .out_take   (out_take),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re         (re),
    .raddr      (raddr),
    .pend       (pend),
    .meta       (meta)
  );

  dq_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr   (raddr),
    .rd_data (rd_data)
  );

  // drive the result word; pushes and failed pops return zero
  assign out_ch.valid     = pend;
  assign out_ch.pop_value = meta.take_data ? rd_data : '0;
  assign out_ch.status    = meta.status;
  assign out_ch.occupancy = meta.occupancy;
  assign out_ch.is_empty  = meta.is_empty;
  assign out_ch.is_full   = meta.is_full;

endmodule

FILE: hdl/dq_mem.sv
// ----------------------------------------------------------------------------
// dq_mem
// Slot storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dq_mem #(
  parameter int DEPTH = dq_pkg::CAPACITY_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [IDX_W-1:0]              waddr,
  input  logic [dq_pkg::DATA_W-1:0]     wdata,
  input  logic                          re,
  input  logic [IDX_W-1:0]              raddr,
  output logic [dq_pkg::DATA_W-1:0]     rd_data
);

  logic [dq_pkg::DATA_W-1:0] mem [DEPTH];

  // write a pushed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read a popped word, hold it until the next pop
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

FILE: hdl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Head/tail pointers, entry count, memory requests and the result stage.
// ----------------------------------------------------------------------------
module dq_ctrl #(
  parameter int CAPACITY = dq_pkg::CAPACITY_DEF,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [dq_pkg::KIND_W-1:0]     kind,
  input  logic [dq_pkg::DATA_W-1:0]     push_value,
  input  logic                          out_take,
  output logic                          we,
  output logic [IDX_W-1:0]              waddr,
  output logic [dq_pkg::DATA_W-1:0]     wdata,
  output logic                          re,
  output logic [IDX_W-1:0]              raddr,
  output logic                          pend,
  output dq_pkg::res_meta_t             meta
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic             is_push, full, empty, ok;
  logic [dq_pkg::STATUS_W-1:0] status_now;

  // wrap the pointers modulo the capacity
  assign head_inc = (head == IDX_LAST) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? IDX_LAST : head - 1'b1;
  assign tail_inc = (tail == IDX_LAST) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? IDX_LAST : tail - 1'b1;

  assign is_push = (kind == dq_pkg::KIND_PUSH_FRONT) || (kind == dq_pkg::KIND_PUSH_BACK);
  assign full    = (count == CNT_CAP);
  assign empty   = (count == '0);
  assign ok      = is_push ? !full : !empty;

  // issue memory requests for the accepted word
  assign we    = accept && is_push && !full;
  assign waddr = (kind == dq_pkg::KIND_PUSH_FRONT) ? head_dec : tail;
  assign wdata = push_value;
  assign re    = accept && !is_push && !empty;
  assign raddr = (kind == dq_pkg::KIND_POP_FRONT) ? head : tail_dec;

  // advance pointers and count
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    status_now = is_push ? dq_pkg::ST_OVERFLOW : dq_pkg::ST_UNDERFLOW;
    if (ok) begin
      status_now = dq_pkg::ST_DONE;
      unique case (kind)
        dq_pkg::KIND_PUSH_FRONT: begin
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
        dq_pkg::KIND_PUSH_BACK: begin
          tail_next  = tail_inc;
          count_next = count + 1'b1;
        end
        dq_pkg::KIND_POP_FRONT: begin
          head_next  = head_inc;
          count_next = count - 1'b1;
        end
        dq_pkg::KIND_POP_BACK: begin
          tail_next  = tail_dec;
          count_next = count - 1'b1;
        end
        default: begin
          head_next = head;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (out_take) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta.status    <= status_now;
      meta.occupancy <= dq_pkg::OCC_W'(count_next);
      meta.is_empty  <= (count_next == '0);
      meta.is_full   <= (count_next == CNT_CAP);
      meta.take_data <= re;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_CAP)
    else $error("entry count above capacity");
  a_ptrs_meet: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (head == tail))
    else $error("head and tail disagree with count");
  a_overflow_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && is_push && full) |=> ($stable(count) && $stable(head) && $stable(tail)))
    else $error("overflowing push changed state");
  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    accept |=> (meta.take_data == (meta.status == dq_pkg::ST_DONE &&
                $past(!is_push))))
    else $error("read data flag mismatch");
`endif

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for double_ended_queue. A short table of operation
// words hits underflow, overflow, index wrap and the data extremes, then
// biased random fill and drain runs sweep the deque between empty and full.
// A behavioral deque predicts every result word. Results are checked in
// order, under random gaps on the operation side and random stalls on the
// result side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP        = 8;
  localparam int IDX_W      = $clog2(CAP);
  localparam int RAND_WORDS = 550;          // per idling phase
  localparam int LIMIT      = 200000;       // watchdog, in cycles
  localparam int MAX_SHOWN  = 10;
  localparam int DIR_N      = 25;

  typedef struct packed {
    logic [dq_pkg::DATA_W-1:0]   pop_value;
    logic [dq_pkg::STATUS_W-1:0] status;
    logic [dq_pkg::OCC_W-1:0]    occupancy;
    logic                        is_empty;
    logic                        is_full;
  } dq_result_t;

  typedef struct packed {
    logic [dq_pkg::KIND_W-1:0] kind;
    logic [dq_pkg::DATA_W-1:0] value;
    logic                      typed;      // expected result given in the row
    dq_result_t                res;
  } dir_row_t;

  localparam dq_result_t NO_RES = '0;

  // Directed operation words; typed rows carry an expected result that is
  // obvious by inspection, the rest rely on the predictor.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // pops right after reset: underflow at either end
    '{dq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b1,
      '{32'h0, dq_pkg::ST_UNDERFLOW, 4'd0, 1'b1, 1'b0}},
    '{dq_pkg::KIND_POP_BACK,   32'hffff_ffff, 1'b1,
      '{32'h0, dq_pkg::ST_UNDERFLOW, 4'd0, 1'b1, 1'b0}},
    // data extremes; push front from index zero wraps the head
    '{dq_pkg::KIND_PUSH_BACK,  32'h7fff_ffff, 1'b1,
      '{32'h0, dq_pkg::ST_DONE, 4'd1, 1'b0, 1'b0}},
    '{dq_pkg::KIND_PUSH_FRONT, 32'h8000_0000, 1'b1,
      '{32'h0, dq_pkg::ST_DONE, 4'd2, 1'b0, 1'b0}},
    '{dq_pkg::KIND_POP_FRONT,  32'h1234_5678, 1'b1,
      '{32'h8000_0000, dq_pkg::ST_DONE, 4'd1, 1'b0, 1'b0}},
    '{dq_pkg::KIND_POP_BACK,   32'h0000_0000, 1'b1,
      '{32'h7fff_ffff, dq_pkg::ST_DONE, 4'd0, 1'b1, 1'b0}},
    // fill from both ends
    '{dq_pkg::KIND_PUSH_FRONT, 32'h0000_0000, 1'b0, NO_RES},
    '{dq_pkg::KIND_PUSH_BACK,  32'hffff_ffff, 1'b0, NO_RES},
    '{dq_pkg::KIND_PUSH_FRONT, 32'h0000_0001, 1'b0, NO_RES},
    '{dq_pkg::KIND_PUSH_BACK,  32'h8000_0000, 1'b0, NO_RES},
    '{dq_pkg::KIND_PUSH_FRONT, 32'h7fff_ffff, 1'b0, NO_RES},
    '{dq_pkg::KIND_PUSH_BACK,  32'h5555_5555, 1'b0, NO_RES},
    '{dq_pkg::KIND_PUSH_FRONT, 32'haaaa_aaaa, 1'b0, NO_RES},
    '{dq_pkg::KIND_PUSH_BACK,  32'h1234_5678, 1'b1,
      '{32'h0, dq_pkg::ST_DONE, 4'd8, 1'b0, 1'b1}},
    // overflow at either end leaves the deque full
    '{dq_pkg::KIND_PUSH_FRONT, 32'hdead_beef, 1'b1,
      '{32'h0, dq_pkg::ST_OVERFLOW, 4'd8, 1'b0, 1'b1}},
    '{dq_pkg::KIND_PUSH_BACK,  32'h0000_0000, 1'b1,
      '{32'h0, dq_pkg::ST_OVERFLOW, 4'd8, 1'b0, 1'b1}},
    // drain from both ends
    '{dq_pkg::KIND_POP_BACK,   32'hffff_ffff, 1'b0, NO_RES},
    '{dq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b0, NO_RES},
    '{dq_pkg::KIND_POP_BACK,   32'h8000_0000, 1'b0, NO_RES},
    '{dq_pkg::KIND_POP_FRONT,  32'h7fff_ffff, 1'b0, NO_RES},
    '{dq_pkg::KIND_POP_FRONT,  32'hffff_ffff, 1'b0, NO_RES},
    '{dq_pkg::KIND_POP_BACK,   32'h0000_0000, 1'b0, NO_RES},
    '{dq_pkg::KIND_POP_FRONT,  32'h5a5a_5a5a, 1'b0, NO_RES},
    '{dq_pkg::KIND_POP_BACK,   32'ha5a5_a5a5, 1'b0, NO_RES},
    '{dq_pkg::KIND_POP_BACK,   32'h0000_0000, 1'b1,
      '{32'h0, dq_pkg::ST_UNDERFLOW, 4'd0, 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst;

  dq_in_if  in_ch ();
  dq_out_if out_ch ();

  double_ended_queue #(.CAPACITY(CAP)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // behavioral deque state
  logic [dq_pkg::DATA_W-1:0] dq_slots [CAP];
  logic [IDX_W-1:0]          dq_head;
  logic [IDX_W-1:0]          dq_tail;
  logic [dq_pkg::OCC_W:0]    dq_count;

  dq_result_t  pending_results [$];
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned err_count;
  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned overflow_seen;
  int unsigned underflow_seen;
  int unsigned full_seen;
  int unsigned cycle_count;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one operation to the behavioral deque and return its result word.
  function automatic dq_result_t deque_apply(input logic [dq_pkg::KIND_W-1:0] kind,
                                             input logic [dq_pkg::DATA_W-1:0] value);
    dq_result_t r;
    r = '0;
    r.status = dq_pkg::ST_DONE;
    case (kind)
      dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_BACK: begin
        if (dq_count == CAP) begin
          r.status = dq_pkg::ST_OVERFLOW;
        end else if (kind == dq_pkg::KIND_PUSH_FRONT) begin
          dq_head = (dq_head == 0) ? IDX_W'(CAP - 1) : dq_head - 1'b1;
          dq_slots[dq_head] = value;
          dq_count = dq_count + 1'b1;
        end else begin
          dq_slots[dq_tail] = value;
          dq_tail = (dq_tail == CAP - 1) ? '0 : dq_tail + 1'b1;
          dq_count = dq_count + 1'b1;
        end
      end
      default: begin
        if (dq_count == 0) begin
          r.status = dq_pkg::ST_UNDERFLOW;
        end else if (kind == dq_pkg::KIND_POP_FRONT) begin
          r.pop_value = dq_slots[dq_head];
          dq_head = (dq_head == CAP - 1) ? '0 : dq_head + 1'b1;
          dq_count = dq_count - 1'b1;
        end else begin
          dq_tail = (dq_tail == 0) ? IDX_W'(CAP - 1) : dq_tail - 1'b1;
          r.pop_value = dq_slots[dq_tail];
          dq_count = dq_count - 1'b1;
        end
      end
    endcase
    r.occupancy = dq_count[dq_pkg::OCC_W-1:0];
    r.is_empty  = (dq_count == 0);
    r.is_full   = (dq_count == CAP);
    return r;
  endfunction

  // Skew data toward the extremes now and then.
  function automatic logic [dq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Send one operation word with random lead-in gaps; on acceptance, queue
  // the typed result if given, else the predicted one.
  task automatic send_word(input logic [dq_pkg::KIND_W-1:0] kind,
                           input logic [dq_pkg::DATA_W-1:0] value,
                           input logic typed, input dq_result_t typed_res);
    dq_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid      <= 1'b0;
      in_ch.kind       <= dq_pkg::KIND_W'($urandom);
      in_ch.push_value <= $urandom;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.push_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = deque_apply(kind, value);
    pending_results.push_back(typed ? typed_res : predicted);
    words_sent++;
  endtask

  // Stall the result side at random.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    dq_result_t want;
    dq_result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.pop_value, out_ch.status, out_ch.occupancy,
              out_ch.is_empty, out_ch.is_full};
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("ERROR: unexpected result word val=%h st=%0d occ=%0d e=%b f=%b",
                   got.pop_value, got.status, got.occupancy, got.is_empty, got.is_full);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.status == dq_pkg::ST_OVERFLOW) overflow_seen++;
        if (got.status == dq_pkg::ST_UNDERFLOW) underflow_seen++;
        if (got.is_full) full_seen++;
        if (got !== want) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("ERROR: result %0d exp val=%h st=%0d occ=%0d e=%b f=%b,",
                     results_checked, want.pop_value, want.status, want.occupancy,
                     want.is_empty, want.is_full,
                     " got val=%h st=%0d occ=%0d e=%b f=%b",
                     got.pop_value, got.status, got.occupancy, got.is_empty,
                     got.is_full);
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: watchdog expired with %0d result words outstanding",
             pending_results.size());
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    logic [dq_pkg::KIND_W-1:0] kind;
    int unsigned               fill_bias;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.kind       = '0;
    in_ch.push_value = '0;
    err_count        = 0;
    words_sent       = 0;
    results_checked  = 0;
    overflow_seen    = 0;
    underflow_seen   = 0;
    full_seen        = 0;
    tx_idle_pct      = 29;
    rx_idle_pct      = 46;
    dq_head          = '0;
    dq_tail          = '0;
    dq_count         = '0;
    fill_bias        = 50;
    for (int i = 0; i < CAP; i++) dq_slots[i] = '0;

    // hold reset, then release
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table
    for (int i = 0; i < DIR_N; i++)
      send_word(DIR_ROWS[i].kind, DIR_ROWS[i].value, DIR_ROWS[i].typed, DIR_ROWS[i].res);

    // random runs: receiver-heavy idling, sender-heavy idling, then none
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 46 : 0;
      rx_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 29 : 0;
      for (int i = 0; i < RAND_WORDS; i++) begin
        // switch between fill, drain and balanced runs every 16 words
        if (i % 16 == 0)
          case ($urandom_range(2))
            0:       fill_bias = 78;
            1:       fill_bias = 22;
            default: fill_bias = 50;
          endcase
        if ($urandom_range(99) < fill_bias)
          kind = $urandom_range(1) ? dq_pkg::KIND_PUSH_BACK : dq_pkg::KIND_PUSH_FRONT;
        else
          kind = $urandom_range(1) ? dq_pkg::KIND_POP_BACK : dq_pkg::KIND_POP_FRONT;
        send_word(kind, pick_value(), 1'b0, NO_RES);
      end
    end
    in_ch.valid <= 1'b0;

    // drain outstanding results, then wait quietly before the summary
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("testbench: %0d operation words sent, %0d result words compared",
             words_sent, results_checked);
    $display("testbench: %0d overflows, %0d underflows, %0d results at full, %0d errors",
             overflow_seen, underflow_seen, full_seen, err_count);
    if (err_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
